### rtl/rau_pkg.sv
// shared types, constants and helpers for the rational arithmetic unit
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int DW    = 2 * WIDTH;
    localparam int CW    = $clog2(DW);

    localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CMP = 3'd4,
        CMD_RED = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVF      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_ERR,
        K_CMP,
        K_ZERO,
        K_FRAC
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_GCD,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic       load;
        logic       mul_step;
        logic [1:0] mul_idx;
        logic       comb;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic early_done;
        logic short_done;
        logic gcd_done;
        logic div_last;
    } dp_stat_t;

    // magnitude of a two's complement value, most negative gives 2^(WIDTH-1)
    function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
        mag_of = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
    endfunction

endpackage

### rtl/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
// usage:
//   input channel (in_valid/in_ready) carries cmd and two signed fractions
//   a_num/a_den and b_num/b_den; one transaction yields exactly one result
//   transaction on the output channel (out_valid/out_ready)
//   commands: add, subtract, multiply, divide, compare, reduce a
//   results are reduced by the gcd with the sign on the numerator; compare
//   drives less/equal/greater only; status flags zero denominators and
//   results that do not fit the operand width
// sequence:
//   one operation at a time; in_ready is high only while the sequencer is idle
//   states S_MUL0, S_MUL1 and S_MUL2 share the single 32x32 multiplier, S_COMB
//   combines the products, S_GCD runs a binary gcd of shift/subtract steps and
//   sees it finish, S_DIV runs two parallel restoring dividers over 64 quotient
//   bits, and S_FIN formats the result into the output register
//   errors and reserved commands skip everything and go straight to formatting;
//   compare and zero results skip gcd and division
//   the next transaction can be taken in the cycle after the result is loaded
// reset and stall:
//   rst_n clears the sequencer and the output valid; there is nothing to sweep
//   the result sits in an output register, so a new transaction is taken while
//   an earlier result waits; a finished result waits for out_ready before
//   overwriting it
module rational_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] a_num,
    input  logic [31:0] a_den,
    input  logic [31:0] b_num,
    input  logic [31:0] b_den,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] res_num,
    output logic [30:0] res_den,
    output logic        less,
    output logic        equal,
    output logic        greater,
    output logic [1:0]  status
);
    import rau_pkg::*;

    // command and status bundles between sequencer and datapath
    dp_cmd_t  ctl;
    dp_stat_t st;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .ctl       (ctl)
    );

    rau_dp u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .ctl     (ctl),
        .st      (st),
        .res_num (res_num),
        .res_den (res_den),
        .less    (less),
        .equal   (equal),
        .greater (greater),
        .status  (status)
    );

endmodule

### rtl/rau_ctrl.sv
// sequencing state machine of the rational arithmetic unit
module rau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rau_pkg::dp_stat_t st,
    output rau_pkg::dp_cmd_t  ctl
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = st.early_done ? S_FIN : S_MUL0;
                end
            end
            S_MUL0: state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_COMB;
            S_COMB: state_next = st.short_done ? S_FIN : S_GCD;
            S_GCD:
            begin
                if (st.gcd_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (st.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            S_IDLE: ctl.load = in_valid;
            S_MUL0:
            begin
                ctl.mul_step = 1'b1;
                ctl.mul_idx  = 2'd0;
            end
            S_MUL1:
            begin
                ctl.mul_step = 1'b1;
                ctl.mul_idx  = 2'd1;
            end
            S_MUL2:
            begin
                ctl.mul_step = 1'b1;
                ctl.mul_idx  = 2'd2;
            end
            S_COMB: ctl.comb = 1'b1;
            S_GCD:
            begin
                ctl.gcd_step = !st.gcd_done;
                ctl.div_init = st.gcd_done;
            end
            S_DIV: ctl.div_step = 1'b1;
            S_FIN: ctl.out_load = !out_valid_reg || out_ready;
            default: ctl = '0;
        endcase
    end

    assign out_valid_next = ctl.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a second transaction while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transfer");

    a_div_follows_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_init |=> (state_reg == S_DIV))
        else $error("division did not start after gcd");

endmodule

### rtl/rau_dp.sv
// datapath: operand decode, shared multiplier, binary gcd and two-lane divider
module rau_dp (
    input  logic              clk,
    input  logic [2:0]        cmd,
    input  logic [31:0]       a_num,
    input  logic [31:0]       a_den,
    input  logic [31:0]       b_num,
    input  logic [31:0]       b_den,
    input  rau_pkg::dp_cmd_t  ctl,
    output rau_pkg::dp_stat_t st,
    output logic [31:0]       res_num,
    output logic [30:0]       res_den,
    output logic              less,
    output logic              equal,
    output logic              greater,
    output logic [1:0]        status
);
    import rau_pkg::*;

    // operand decode
    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
    logic             in_an_neg, in_bn_neg, in_err, in_rsv;

    assign in_an     = mag_of(a_num[WIDTH-1:0]);
    assign in_ad     = mag_of(a_den[WIDTH-1:0]);
    assign in_bn     = mag_of(b_num[WIDTH-1:0]);
    assign in_bd     = mag_of(b_den[WIDTH-1:0]);
    assign in_an_neg = a_num[WIDTH-1] ^ a_den[WIDTH-1];
    assign in_bn_neg = b_num[WIDTH-1] ^ b_den[WIDTH-1];
    assign in_rsv    = (cmd > CMD_RED);
    assign in_err    = (in_ad == '0) || ((cmd != CMD_RED) && (in_bd == '0))
                    || ((cmd == CMD_DIV) && (in_bn == '0));
    assign st.early_done = in_rsv || in_err;

    logic [2:0]       cmd_reg;
    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic             an_neg_reg, bn_neg_reg;
    kind_t            kind_reg;
    logic [DW-1:0]    p1_reg, p2_reg, den_reg, nm_reg;
    logic             num_neg_reg, lt_reg, eq_reg, gt_reg;
    logic [DW-1:0]    u_reg, v_reg, g_reg;
    logic [CW-1:0]    k_reg, cnt_reg;
    logic [DW-1:0]    q1_reg, q2_reg, r1_reg, r2_reg;

    // shared multiplier
    logic [WIDTH-1:0] mx, my;
    logic [DW-1:0]    prod;

    always_comb
    begin
        case (ctl.mul_idx)
            2'd0:
            begin
                mx = an_reg;
                my = (cmd_reg == CMD_RED) ? WIDTH'(1)
                   : (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                mx = bn_reg;
                my = ad_reg;
            end
            2'd2:
            begin
                mx = ad_reg;
                my = (cmd_reg == CMD_RED) ? WIDTH'(1)
                   : (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    assign prod = mx * my;

    // combine products
    logic          t2_neg, c_neg, xn, yn;
    logic [DW-1:0] c_mag;

    always_comb
    begin
        t2_neg = (cmd_reg == CMD_SUB) ? !bn_neg_reg : bn_neg_reg;
        if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)
        begin
            if (an_neg_reg == t2_neg)
            begin
                c_neg = an_neg_reg;
                c_mag = p1_reg + p2_reg;
            end
            else if (p1_reg >= p2_reg)
            begin
                c_neg = an_neg_reg;
                c_mag = p1_reg - p2_reg;
            end
            else
            begin
                c_neg = t2_neg;
                c_mag = p2_reg - p1_reg;
            end
        end
        else if (cmd_reg == CMD_RED)
        begin
            c_neg = an_neg_reg;
            c_mag = p1_reg;
        end
        else
        begin
            c_neg = an_neg_reg ^ bn_neg_reg;
            c_mag = p1_reg;
        end
    end

    assign xn = an_neg_reg && (p1_reg != '0);
    assign yn = bn_neg_reg && (p2_reg != '0);
    assign st.short_done = (cmd_reg == CMD_CMP) || (c_mag == '0);

    logic c_lt, c_eq;
    assign c_eq = (xn == yn) && (p1_reg == p2_reg);
    assign c_lt = (xn != yn) ? xn : (xn ? (p1_reg > p2_reg) : (p1_reg < p2_reg));

    // divider lanes
    logic [DW:0] rs1, rs2;
    logic        ge1, ge2;
    assign rs1 = {r1_reg, q1_reg[DW-1]};
    assign rs2 = {r2_reg, q2_reg[DW-1]};
    assign ge1 = rs1 >= {1'b0, g_reg};
    assign ge2 = rs2 >= {1'b0, g_reg};

    assign st.gcd_done = (u_reg == v_reg);
    assign st.div_last = (cnt_reg == CW'(DW - 1));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            an_reg     <= in_an;
            ad_reg     <= in_ad;
            bn_reg     <= in_bn;
            bd_reg     <= in_bd;
            an_neg_reg <= in_an_neg;
            bn_neg_reg <= in_bn_neg;
            kind_reg   <= in_rsv ? K_NONE : (in_err ? K_ERR : K_FRAC);
        end
        if (ctl.mul_step)
        begin
            case (ctl.mul_idx)
                2'd0:    p1_reg  <= prod;
                2'd1:    p2_reg  <= prod;
                default: den_reg <= prod;
            endcase
        end
        if (ctl.comb)
        begin
            num_neg_reg <= c_neg;
            nm_reg      <= c_mag;
            u_reg       <= c_mag;
            v_reg       <= den_reg;
            k_reg       <= '0;
            lt_reg      <= c_lt;
            eq_reg      <= c_eq;
            gt_reg      <= !c_lt && !c_eq;
            kind_reg    <= (cmd_reg == CMD_CMP) ? K_CMP : ((c_mag == '0) ? K_ZERO : K_FRAC);
        end
        if (ctl.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + CW'(1);
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg > v_reg)
            begin
                u_reg <= u_reg - v_reg;
            end
            else
            begin
                v_reg <= v_reg - u_reg;
            end
        end
        if (ctl.div_init)
        begin
            g_reg   <= u_reg << k_reg;
            q1_reg  <= nm_reg;
            q2_reg  <= den_reg;
            r1_reg  <= '0;
            r2_reg  <= '0;
            cnt_reg <= '0;
        end
        if (ctl.div_step)
        begin
            r1_reg  <= ge1 ? DW'(rs1 - {1'b0, g_reg}) : rs1[DW-1:0];
            r2_reg  <= ge2 ? DW'(rs2 - {1'b0, g_reg}) : rs2[DW-1:0];
            q1_reg  <= {q1_reg[DW-2:0], ge1};
            q2_reg  <= {q2_reg[DW-2:0], ge2};
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // result formatting
    logic                    ovf;
    logic signed [WIDTH-1:0] snum;
    logic [31:0]             f_num;
    logic [30:0]             f_den;
    logic                    f_lt, f_eq, f_gt;
    logic [1:0]              f_st;

    assign ovf  = (q2_reg > LIM - DW'(1))
               || (q1_reg > (num_neg_reg ? LIM : LIM - DW'(1)));
    assign snum = num_neg_reg ? (~q1_reg[WIDTH-1:0] + WIDTH'(1)) : q1_reg[WIDTH-1:0];

    always_comb
    begin
        f_num = '0;
        f_den = '0;
        f_lt  = 1'b0;
        f_eq  = 1'b0;
        f_gt  = 1'b0;
        f_st  = ST_OK;
        case (kind_reg)
            K_NONE: f_st = ST_OK;
            K_ERR:  f_st = ST_ZERO_DEN;
            K_CMP:
            begin
                f_lt = lt_reg;
                f_eq = eq_reg;
                f_gt = gt_reg;
            end
            K_ZERO: f_den = 31'd1;
            K_FRAC:
            begin
                if (ovf)
                begin
                    f_st = ST_OVF;
                end
                else
                begin
                    f_num = 32'(snum);
                    f_den = 31'(q2_reg[WIDTH-2:0]);
                end
            end
            default: f_st = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            res_num <= f_num;
            res_den <= f_den;
            less    <= f_lt;
            equal   <= f_eq;
            greater <= f_gt;
            status  <= f_st;
        end
    end

endmodule
